>>> hw/rtl/co2uf_pkg.sv
// Shared constants for the CO2 sensor UART framer: operation codes,
// command opcodes and frame layout constants.
// No dependencies.
`default_nettype none

package co2uf_pkg;

    // Operation codes of an input word
    localparam logic [2:0] OP_RX_BYTE     = 3'd0;
    localparam logic [2:0] OP_READ        = 3'd1;
    localparam logic [2:0] OP_ZERO_CAL    = 3'd2;
    localparam logic [2:0] OP_SPAN_CAL    = 3'd3;
    localparam logic [2:0] OP_AUTOCAL_ON  = 3'd4;
    localparam logic [2:0] OP_AUTOCAL_OFF = 3'd5;

    // Frame layout
    localparam int unsigned FRAME_BYTES = 9;
    localparam int unsigned IDX_W       = $clog2(FRAME_BYTES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_BYTES - 1);

    // Fixed frame bytes
    localparam logic [7:0] START_BYTE  = 8'hff;
    localparam logic [7:0] SENSOR_ID   = 8'h01;
    localparam logic [7:0] RESP_READ   = 8'h86;
    localparam logic [7:0] CMD_READ    = 8'h86;
    localparam logic [7:0] CMD_ZERO    = 8'h87;
    localparam logic [7:0] CMD_SPAN    = 8'h88;
    localparam logic [7:0] CMD_AUTOCAL = 8'h79;
    localparam logic [7:0] AUTOCAL_ARG = 8'hA0;

    // Span commands below this concentration are dropped
    localparam logic [15:0] SPAN_MIN    = 16'd1000;
    localparam logic [8:0]  TEMP_OFFSET = 9'd40;

endpackage

`default_nettype wire

>>> hw/rtl/co2_sensor_uart_framer_top.sv
// An accepted word's first result word is registered and shown in the next cycle.
// Received bytes are taken one per cycle unless the output stalls or a frame
// drains; a command word yields nine result words in order from the frame byte
// sequencer, and the input holds ready low while bytes two to nine drain.
// Reset (rst_n, asynchronous, active low) empties the output register, stops
// the sequencer and restarts the response gatherer with header flag set.
`default_nettype none

module co2_sensor_uart_framer_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [2:0]  operation,
    input  wire logic [7:0]  rx_data,
    input  wire logic [15:0] span_ppm,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             tx_valid,
    output logic [7:0]       tx_data,
    output logic             tx_last,
    output logic             meas_valid,
    output logic             frame_ok,
    output logic [15:0]      co2_ppm,
    output logic signed [8:0] temperature_c,
    output logic [7:0]       sensor_status
);
    import co2uf_pkg::*;

    // Output register
    logic        out_valid_reg, out_valid_next;
    logic        tx_valid_reg, tx_valid_next;
    logic [7:0]  tx_data_reg, tx_data_next;
    logic        tx_last_reg, tx_last_next;
    logic        meas_valid_reg, meas_valid_next;
    logic        frame_ok_reg, frame_ok_next;
    logic [15:0] co2_ppm_reg, co2_ppm_next;
    logic [8:0]  temp_reg, temp_next;
    logic [7:0]  status_reg, status_next;

    // Command frame sequencer
    logic             tx_busy_reg, tx_busy_next;
    logic [IDX_W-1:0] tx_idx_reg, tx_idx_next;
    logic [7:0]       cmd_op_reg, cmd_op_next;
    logic [7:0]       cmd_arg3_reg, cmd_arg3_next;
    logic [7:0]       cmd_arg4_reg, cmd_arg4_next;
    logic [7:0]       cmd_check_reg, cmd_check_next;

    // Response gatherer
    logic [IDX_W-1:0] rx_pos_reg, rx_pos_next;
    logic [7:0]       rx_sum_reg, rx_sum_next;
    logic             rx_hdr_reg, rx_hdr_next;
    logic [15:0]      rx_co2_reg, rx_co2_next;
    logic [7:0]       rx_temp_reg, rx_temp_next;
    logic [7:0]       rx_status_reg, rx_status_next;

    logic load_en, in_fire, is_cmd, cmd_fire, rx_fire, rx_done;
    logic [7:0] new_op, new_arg3, new_arg4, new_sum;
    logic [7:0] seq_byte;

    // Handshake
    assign load_en  = !out_valid_reg || out_ready;
    assign in_ready = load_en && !tx_busy_reg;
    assign in_fire  = in_valid && in_ready;
    assign rx_fire  = in_fire && (operation == OP_RX_BYTE);
    assign rx_done  = rx_fire && (rx_pos_reg >= LAST_IDX);
    assign cmd_fire = in_fire && is_cmd;

    // Decode command opcode and arguments
    always_comb
    begin
        is_cmd   = 1'b1;
        new_op   = CMD_AUTOCAL;
        new_arg3 = 8'h00;
        new_arg4 = 8'h00;
        unique case (operation)
            OP_READ:        new_op = CMD_READ;
            OP_ZERO_CAL:    new_op = CMD_ZERO;
            OP_SPAN_CAL:
            begin
                new_op   = CMD_SPAN;
                new_arg3 = span_ppm[15:8];
                new_arg4 = span_ppm[7:0];
                is_cmd   = (span_ppm >= SPAN_MIN);
            end
            OP_AUTOCAL_ON:
            begin
                new_op   = CMD_AUTOCAL;
                new_arg3 = AUTOCAL_ARG;
            end
            OP_AUTOCAL_OFF: new_op = CMD_AUTOCAL;
            default:        is_cmd = 1'b0;
        endcase
        new_sum = SENSOR_ID + new_op + new_arg3 + new_arg4;
    end

    // Pick the frame byte at the sequencer position
    always_comb
    begin
        unique case (tx_idx_reg)
            IDX_W'(0): seq_byte = START_BYTE;
            IDX_W'(1): seq_byte = SENSOR_ID;
            IDX_W'(2): seq_byte = cmd_op_reg;
            IDX_W'(3): seq_byte = cmd_arg3_reg;
            IDX_W'(4): seq_byte = cmd_arg4_reg;
            LAST_IDX:  seq_byte = cmd_check_reg;
            default:   seq_byte = 8'h00;
        endcase
    end

    // Sequencer and command frame registers
    always_comb
    begin
        tx_busy_next   = tx_busy_reg;
        tx_idx_next    = tx_idx_reg;
        cmd_op_next    = cmd_op_reg;
        cmd_arg3_next  = cmd_arg3_reg;
        cmd_arg4_next  = cmd_arg4_reg;
        cmd_check_next = cmd_check_reg;
        if (cmd_fire)
        begin
            tx_busy_next   = 1'b1;
            tx_idx_next    = IDX_W'(1);
            cmd_op_next    = new_op;
            cmd_arg3_next  = new_arg3;
            cmd_arg4_next  = new_arg4;
            cmd_check_next = 8'h00 - new_sum;
        end
        else if (tx_busy_reg && load_en)
        begin
            tx_idx_next  = tx_idx_reg + IDX_W'(1);
            tx_busy_next = (tx_idx_reg != LAST_IDX);
        end
    end

    // Gather response bytes; a read command restarts the gatherer
    always_comb
    begin
        rx_pos_next    = rx_pos_reg;
        rx_sum_next    = rx_sum_reg;
        rx_hdr_next    = rx_hdr_reg;
        rx_co2_next    = rx_co2_reg;
        rx_temp_next   = rx_temp_reg;
        rx_status_next = rx_status_reg;
        if (rx_fire)
        begin
            if (rx_pos_reg == IDX_W'(0) && rx_data != START_BYTE)
                rx_hdr_next = 1'b0;
            if (rx_pos_reg == IDX_W'(1) && rx_data != RESP_READ)
                rx_hdr_next = 1'b0;
            if (rx_pos_reg == IDX_W'(2))
                rx_co2_next[15:8] = rx_data;
            if (rx_pos_reg == IDX_W'(3))
                rx_co2_next[7:0] = rx_data;
            if (rx_pos_reg == IDX_W'(4))
                rx_temp_next = rx_data;
            if (rx_pos_reg == IDX_W'(5))
                rx_status_next = rx_data;
            if (rx_done)
            begin
                rx_pos_next = '0;
                rx_sum_next = 8'h00;
                rx_hdr_next = 1'b1;
            end
            else
            begin
                if (rx_pos_reg != IDX_W'(0))
                    rx_sum_next = rx_sum_reg + rx_data;
                rx_pos_next = rx_pos_reg + IDX_W'(1);
            end
        end
        else if (cmd_fire && operation == OP_READ)
        begin
            rx_pos_next = '0;
            rx_sum_next = 8'h00;
            rx_hdr_next = 1'b1;
        end
    end

    // Load the output register: sequencer bytes first, then new words
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        tx_valid_next   = tx_valid_reg;
        tx_data_next    = tx_data_reg;
        tx_last_next    = tx_last_reg;
        meas_valid_next = meas_valid_reg;
        frame_ok_next   = frame_ok_reg;
        co2_ppm_next    = co2_ppm_reg;
        temp_next       = temp_reg;
        status_next     = status_reg;
        if (load_en)
        begin
            out_valid_next  = 1'b1;
            tx_valid_next   = 1'b0;
            tx_data_next    = 8'h00;
            tx_last_next    = 1'b0;
            meas_valid_next = 1'b0;
            frame_ok_next   = 1'b0;
            co2_ppm_next    = 16'h0000;
            temp_next       = 9'h000;
            status_next     = 8'h00;
            priority if (tx_busy_reg)
            begin
                tx_valid_next = 1'b1;
                tx_data_next  = seq_byte;
                tx_last_next  = (tx_idx_reg == LAST_IDX);
            end
            else if (cmd_fire)
            begin
                tx_valid_next = 1'b1;
                tx_data_next  = START_BYTE;
            end
            else if (rx_done)
            begin
                meas_valid_next = 1'b1;
                frame_ok_next   = rx_hdr_reg && ((8'h00 - rx_sum_reg) == rx_data);
                co2_ppm_next    = rx_co2_reg;
                temp_next       = {1'b0, rx_temp_reg} - TEMP_OFFSET;
                status_next     = rx_status_reg;
            end
            else
            begin
                // Nothing to present: empty the register
                out_valid_next = 1'b0;
            end
        end
    end

    // Control and gatherer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            tx_busy_reg   <= 1'b0;
            tx_idx_reg    <= '0;
            rx_pos_reg    <= '0;
            rx_sum_reg    <= 8'h00;
            rx_hdr_reg    <= 1'b1;
            rx_co2_reg    <= 16'h0000;
            rx_temp_reg   <= 8'h00;
            rx_status_reg <= 8'h00;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            tx_busy_reg   <= tx_busy_next;
            tx_idx_reg    <= tx_idx_next;
            rx_pos_reg    <= rx_pos_next;
            rx_sum_reg    <= rx_sum_next;
            rx_hdr_reg    <= rx_hdr_next;
            rx_co2_reg    <= rx_co2_next;
            rx_temp_reg   <= rx_temp_next;
            rx_status_reg <= rx_status_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        tx_valid_reg   <= tx_valid_next;
        tx_data_reg    <= tx_data_next;
        tx_last_reg    <= tx_last_next;
        meas_valid_reg <= meas_valid_next;
        frame_ok_reg   <= frame_ok_next;
        co2_ppm_reg    <= co2_ppm_next;
        temp_reg       <= temp_next;
        status_reg     <= status_next;
        cmd_op_reg     <= cmd_op_next;
        cmd_arg3_reg   <= cmd_arg3_next;
        cmd_arg4_reg   <= cmd_arg4_next;
        cmd_check_reg  <= cmd_check_next;
    end

    // Drive outputs
    assign out_valid     = out_valid_reg;
    assign tx_valid      = tx_valid_reg;
    assign tx_data       = tx_data_reg;
    assign tx_last       = tx_last_reg;
    assign meas_valid    = meas_valid_reg;
    assign frame_ok      = frame_ok_reg;
    assign co2_ppm       = co2_ppm_reg;
    assign temperature_c = $signed(temp_reg);
    assign sensor_status = status_reg;

    // A result word is either a command byte or a measurement, never both
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (tx_valid_reg != meas_valid_reg))
    else $error("result word is neither or both of command and measurement");

    // The gatherer never runs past the last frame position
    assert property (@(posedge clk) disable iff (!rst_n)
        rx_pos_reg <= LAST_IDX)
    else $error("response position out of range");

    // The sequencer is idle while the checksum byte waits
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && tx_last_reg) |-> !tx_busy_reg)
    else $error("sequencer still busy after last frame byte");

    // A new command frame starts right after its opening byte
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_fire |=> (tx_busy_reg && tx_idx_reg == IDX_W'(1)
                      && out_valid_reg && tx_data_reg == START_BYTE))
    else $error("command frame did not start correctly");

endmodule

`default_nettype wire
